// ===== hdl/sdcdc_pkg.sv =====
// Shared types, constants and the divider step for the SD clock divider calculator.
package sdcdc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned VER_W = 8;
    localparam int unsigned FIELD_W = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned BITS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES = DATA_W / BITS_PER_STAGE;

    localparam logic [DATA_W-1:0] BASE_CLOCK_RESET = 32'd41666666;
    localparam logic [VER_W-1:0] HOST_VERSION_RESET = 8'd0;
    localparam logic [VER_W-1:0] DIRECT_MIN_VERSION = 8'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_CLOCK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_VERSION = 1'd1;

    typedef struct packed {
        logic direct;
        logic zero;
    } t_side;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
    } t_div_st;

    function automatic t_div_st div_step(input t_div_st st, input logic [DATA_W-1:0] den);
        logic [DATA_W:0] trial;
        t_div_st res;
        trial = {st.rem, st.quo[DATA_W-1]};
        if (trial >= {1'b0, den}) begin
            trial = trial - {1'b0, den};
            res.quo = {st.quo[DATA_W-2:0], 1'b1};
        end else begin
            res.quo = {st.quo[DATA_W-2:0], 1'b0};
        end
        res.rem = trial[DATA_W-1:0];
        return res;
    endfunction

endpackage

// ===== hdl/sdcdc_req_if.sv =====
// Request channel interface carrying the target card clock frequency.
interface sdcdc_req_if;
    logic                           valid;
    logic                           ready;
    logic [sdcdc_pkg::DATA_W-1:0]   target_hz;

    modport source (output valid, output target_hz, input ready);
    modport sink (input valid, input target_hz, output ready);
endinterface

// ===== hdl/sdcdc_rsp_if.sv =====
// Response channel interface carrying the clock control divider field.
interface sdcdc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [sdcdc_pkg::FIELD_W-1:0]  divider_field;
    logic                           zero_target;

    modport source (output valid, output divider_field, output zero_target, input ready);
    modport sink (input valid, input divider_field, input zero_target, output ready);
endinterface

// ===== hdl/sdcdc_div.sv =====
// Pipelined restoring divider that retires a fixed number of quotient bits per stage.
module sdcdc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic [sdcdc_pkg::DATA_W-1:0]    i_num,
    input  logic [sdcdc_pkg::DATA_W-1:0]    i_den,
    input  sdcdc_pkg::t_side                i_side,
    output logic                            o_vld,
    output logic [sdcdc_pkg::DATA_W-1:0]    o_quo,
    output sdcdc_pkg::t_side                o_side
);

    localparam int unsigned NS = sdcdc_pkg::DIV_STAGES;

    logic                           r_vld  [NS];
    sdcdc_pkg::t_div_st             r_st   [NS];
    logic [sdcdc_pkg::DATA_W-1:0]   r_den  [NS];
    sdcdc_pkg::t_side               r_side [NS];

    sdcdc_pkg::t_div_st             w_st   [NS];
    logic [sdcdc_pkg::DATA_W-1:0]   w_den  [NS];
    logic                           w_vld  [NS];
    sdcdc_pkg::t_side               w_side [NS];
    sdcdc_pkg::t_div_st             n_st   [NS];

    always_comb begin
        w_st[0]   = '{rem: '0, quo: i_num};
        w_den[0]  = i_den;
        w_vld[0]  = i_vld;
        w_side[0] = i_side;
        for (int k = 1; k < NS; k++) begin
            w_st[k]   = r_st[k-1];
            w_den[k]  = r_den[k-1];
            w_vld[k]  = r_vld[k-1];
            w_side[k] = r_side[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            n_st[k] = w_st[k];
            for (int j = 0; j < sdcdc_pkg::BITS_PER_STAGE; j++) begin
                n_st[k] = sdcdc_pkg::div_step(n_st[k], w_den[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= w_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_st[k]   <= n_st[k];
                r_den[k]  <= w_den[k];
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_quo  = r_st[NS-1].quo;
    assign o_side = r_side[NS-1];

endmodule

// ===== hdl/sd_clock_divider_calc_unit.sv =====
// Top level of the SD clock divider calculator: config registers, input and output stages.
// Each request carries a target card clock; the block divides the base clock by it and
// returns the clock control divider field, with a flag when the target is zero. One
// request is accepted every cycle while no result waits to be taken; each result passes
// one input register, a 16-stage divider that settles two quotient bits per stage, and
// one output register. The whole pipeline holds while a result waits to be taken.
// Configuration writes take effect at once and should be made while no request is in
// flight.
module sd_clock_divider_calc_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sdcdc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sdcdc_pkg::DATA_W-1:0]        i_cfg_data,
    sdcdc_req_if.sink                           i_req,
    sdcdc_rsp_if.source                         o_rsp
);

    logic [sdcdc_pkg::DATA_W-1:0]   r_base_clock_hz;
    logic [sdcdc_pkg::VER_W-1:0]    r_host_version;

    logic                           w_adv;
    logic                           r_in_vld;
    logic [sdcdc_pkg::DATA_W-1:0]   r_in_num;
    logic [sdcdc_pkg::DATA_W-1:0]   r_in_den;
    sdcdc_pkg::t_side               r_in_side;

    logic                           w_div_vld;
    logic [sdcdc_pkg::DATA_W-1:0]   w_div_quo;
    sdcdc_pkg::t_side               w_div_side;

    logic                           r_out_vld;
    logic [sdcdc_pkg::FIELD_W-1:0]  r_out_field;
    logic                           r_out_zero;

    logic [sdcdc_pkg::DATA_W-1:0]   w_cm1;
    logic [2:0]                     w_shift;
    logic [9:0]                     w_div;
    logic [sdcdc_pkg::FIELD_W-1:0]  n_out_field;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_clock_hz <= sdcdc_pkg::BASE_CLOCK_RESET;
            r_host_version  <= sdcdc_pkg::HOST_VERSION_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sdcdc_pkg::CFG_BASE_CLOCK:   r_base_clock_hz <= i_cfg_data;
                sdcdc_pkg::CFG_HOST_VERSION: r_host_version  <= i_cfg_data[sdcdc_pkg::VER_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_adv       = !r_out_vld || o_rsp.ready;
    assign i_req.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_adv) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_num         <= r_base_clock_hz;
            r_in_den         <= i_req.target_hz;
            r_in_side.direct <= r_host_version >= sdcdc_pkg::DIRECT_MIN_VERSION;
            r_in_side.zero   <= i_req.target_hz == '0;
        end
    end

    sdcdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_in_vld),
        .i_num   (r_in_num),
        .i_den   (r_in_den),
        .i_side  (r_in_side),
        .o_vld   (w_div_vld),
        .o_quo   (w_div_quo),
        .o_side  (w_div_side)
    );

    always_comb begin
        w_cm1   = w_div_quo - 32'd1;
        w_shift = 3'd0;
        if (w_cm1[sdcdc_pkg::DATA_W-1:7] != '0) begin
            w_shift = 3'd7;
        end else begin
            for (int i = 0; i < 7; i++) begin
                if (w_cm1[i]) begin
                    w_shift = 3'(i);
                end
            end
        end
        if (w_div_side.direct) begin
            if (w_div_quo <= 32'd2) begin
                w_div = 10'd2;
            end else begin
                w_div = w_div_quo[9:0];
            end
        end else begin
            if (w_shift <= 3'd1) begin
                w_div = 10'd2;
            end else begin
                w_div = 10'd1 << w_shift;
            end
        end
        if (w_div_side.zero) begin
            n_out_field = '0;
        end else begin
            n_out_field = {w_div[7:0], w_div[9:8], 6'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_field <= n_out_field;
            r_out_zero  <= w_div_side.zero;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.divider_field = r_out_field;
    assign o_rsp.zero_target   = r_out_zero;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the SD clock divider calculator: directed table, random phases.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [sdcdc_pkg::FIELD_W-1:0] divider_field;
        logic                          zero_target;
    } t_clkdiv_result;

    typedef struct packed {
        logic [sdcdc_pkg::DATA_W-1:0] target_hz;
        t_clkdiv_result               result;
    } t_pending_div;

    typedef struct packed {
        logic [sdcdc_pkg::DATA_W-1:0]  base_clock;
        logic [sdcdc_pkg::VER_W-1:0]   host_version;
        logic [sdcdc_pkg::DATA_W-1:0]  target_hz;
        bit                            typed;
        logic [sdcdc_pkg::FIELD_W-1:0] divider_field;
        logic                          zero_target;
    } t_stim_row;

    localparam int unsigned NUM_ROWS = 23;
    localparam int unsigned NUM_PHASES = 12;
    localparam int unsigned ITEMS_PER_PHASE = 90;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam logic [sdcdc_pkg::DATA_W-1:0] BASE_MAX = 32'hFFFF_FFFF;
    localparam logic [sdcdc_pkg::DATA_W-1:0] BASE_RST = sdcdc_pkg::BASE_CLOCK_RESET;

    localparam t_stim_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{BASE_RST,         8'd0, 32'd0,          1'b1, 16'h0000, 1'b1},
        '{BASE_RST,         8'd0, 32'd400000,     1'b0, 16'h0000, 1'b0},
        '{BASE_RST,         8'd0, 32'd1,          1'b1, 16'h8000, 1'b0},
        '{BASE_RST,         8'd0, 32'hFFFF_FFFF,  1'b1, 16'h8000, 1'b0},
        '{BASE_RST,         8'd0, 32'd41666666,   1'b1, 16'h0200, 1'b0},
        '{BASE_RST,         8'd0, 32'd20833333,   1'b0, 16'h0000, 1'b0},
        '{BASE_RST,         8'd0, 32'd2000000,    1'b0, 16'h0000, 1'b0},
        '{BASE_RST,         8'd2, 32'd0,          1'b1, 16'h0000, 1'b1},
        '{BASE_RST,         8'd2, 32'hFFFF_FFFF,  1'b1, 16'h0200, 1'b0},
        '{BASE_RST,         8'd2, 32'd41666666,   1'b1, 16'h0200, 1'b0},
        '{BASE_RST,         8'd2, 32'd400000,     1'b0, 16'h0000, 1'b0},
        '{BASE_RST,         8'd2, 32'd1,          1'b0, 16'h0000, 1'b0},
        '{BASE_MAX,         8'd255, 32'd1,        1'b1, 16'hFFC0, 1'b0},
        '{BASE_MAX,         8'd255, 32'd4198404,  1'b0, 16'h0000, 1'b0},
        '{BASE_MAX,         8'd255, 32'hFFFF_FFFF, 1'b1, 16'h0200, 1'b0},
        '{BASE_MAX,         8'd255, 32'd0,        1'b1, 16'h0000, 1'b1},
        '{32'd1,            8'd1, 32'd1,          1'b1, 16'h0200, 1'b0},
        '{32'd1,            8'd1, 32'd2,          1'b1, 16'h8000, 1'b0},
        '{32'd1,            8'd2, 32'd2,          1'b1, 16'h0200, 1'b0},
        '{BASE_MAX,         8'd0, 32'd1,          1'b1, 16'h8000, 1'b0},
        '{BASE_MAX,         8'd0, 32'h2000_0000,  1'b0, 16'h0000, 1'b0},
        '{BASE_MAX,         8'd0, 32'd3,          1'b0, 16'h0000, 1'b0},
        '{32'd1000,         8'd3, 32'd3,          1'b0, 16'h0000, 1'b0}
    };

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [sdcdc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [sdcdc_pkg::DATA_W-1:0]    i_cfg_data;

    sdcdc_req_if req_if ();
    sdcdc_rsp_if rsp_if ();

    sd_clock_divider_calc_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    logic [sdcdc_pkg::DATA_W-1:0] cur_base_clock;
    logic [sdcdc_pkg::VER_W-1:0]  cur_host_version;
    t_pending_div                 pending_results [$];
    int unsigned                  error_count = 0;
    int unsigned                  sender_idle_pct = 0;
    int unsigned                  receiver_stall_pct = 0;
    int unsigned                  holdoff_left = 0;
    int unsigned                  quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_clkdiv_result predict_divider(
            input logic [sdcdc_pkg::DATA_W-1:0] target,
            input logic [sdcdc_pkg::DATA_W-1:0] base,
            input logic [sdcdc_pkg::VER_W-1:0] version);
        logic [sdcdc_pkg::DATA_W-1:0] quotient;
        logic [sdcdc_pkg::DATA_W-1:0] less_one;
        logic [sdcdc_pkg::DATA_W-1:0] divisor;
        int unsigned                  shift;
        int unsigned                  b;
        bit                           direct;
        t_clkdiv_result               r;
        r = '0;
        if (target == '0) begin
            r.zero_target = 1'b1;
            return r;
        end
        direct = (version >= sdcdc_pkg::DIRECT_MIN_VERSION);
        quotient = base / target;
        less_one = quotient - 32'd1;
        shift = 0;
        if (less_one >= 32'd256) begin
            shift = 7;
        end else begin
            for (b = 0; b < 8; b++) begin
                if (less_one[b]) begin
                    shift = b;
                end
            end
        end
        divisor = direct ? quotient : (32'd1 << shift);
        if (divisor <= 32'd2) begin
            divisor = 32'd2;
        end
        r.divider_field = {divisor[7:0], 8'h00};
        if (direct) begin
            r.divider_field[7:6] = divisor[9:8];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic send_request(input logic [sdcdc_pkg::DATA_W-1:0] target, input bit typed,
                                input t_clkdiv_result typed_result);
        t_pending_div entry;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.target_hz <= target;
        do @(posedge i_clk); while (!req_if.ready);
        entry.target_hz = target;
        entry.result = typed ? typed_result
                             : predict_divider(target, cur_base_clock, cur_host_version);
        pending_results.push_back(entry);
    endtask

    task automatic drain_requests();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic configure(input logic [sdcdc_pkg::DATA_W-1:0] base,
                             input logic [sdcdc_pkg::VER_W-1:0] version);
        logic [sdcdc_pkg::DATA_W-1:0] ver_word;
        ver_word = $urandom();
        ver_word[sdcdc_pkg::VER_W-1:0] = version;
        i_cfg_we <= 1'b1;
        i_cfg_index <= sdcdc_pkg::CFG_BASE_CLOCK;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_index <= sdcdc_pkg::CFG_HOST_VERSION;
        i_cfg_data <= ver_word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_base_clock = base;
        cur_host_version = version;
    endtask

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_left > 0) begin
                rsp_if.ready <= 1'b0;
                holdoff_left--;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pending_div want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result field %h zero %b",
                                          rsp_if.divider_field, rsp_if.zero_target));
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.divider_field !== want.result.divider_field) begin
                    report_mismatch($sformatf("target %h: divider_field %h, expected %h",
                                              want.target_hz, rsp_if.divider_field,
                                              want.result.divider_field));
                end
                if (rsp_if.zero_target !== want.result.zero_target) begin
                    report_mismatch($sformatf("target %h: zero_target %b, expected %b",
                                              want.target_hz, rsp_if.zero_target,
                                              want.result.zero_target));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned                  row;
        int unsigned                  phase;
        int unsigned                  item;
        int unsigned                  ratio;
        logic [sdcdc_pkg::DATA_W-1:0] base;
        logic [sdcdc_pkg::VER_W-1:0]  version;
        logic [sdcdc_pkg::DATA_W-1:0] target;
        t_clkdiv_result               typed_result;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= sdcdc_pkg::CFG_BASE_CLOCK;
        i_cfg_data <= '0;
        req_if.valid <= 1'b0;
        req_if.target_hz <= '0;
        cur_base_clock = sdcdc_pkg::BASE_CLOCK_RESET;
        cur_host_version = sdcdc_pkg::HOST_VERSION_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < NUM_ROWS; row++) begin
            if (DIRECTED_ROWS[row].base_clock != cur_base_clock ||
                DIRECTED_ROWS[row].host_version != cur_host_version) begin
                drain_requests();
                configure(DIRECTED_ROWS[row].base_clock, DIRECTED_ROWS[row].host_version);
            end
            typed_result.divider_field = DIRECTED_ROWS[row].divider_field;
            typed_result.zero_target = DIRECTED_ROWS[row].zero_target;
            send_request(DIRECTED_ROWS[row].target_hz, DIRECTED_ROWS[row].typed, typed_result);
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain_requests();
            case (phase)
                0: begin
                    base = BASE_MAX;
                    version = 8'd255;
                end
                1: begin
                    base = 32'd1;
                    version = 8'd0;
                end
                2: begin
                    base = sdcdc_pkg::BASE_CLOCK_RESET;
                    version = 8'd1;
                end
                3: begin
                    base = sdcdc_pkg::BASE_CLOCK_RESET;
                    version = sdcdc_pkg::DIRECT_MIN_VERSION;
                end
                default: begin
                    case ($urandom_range(3))
                        0: base = $urandom();
                        1: base = $urandom_range(5000, 1);
                        2: base = $urandom_range(200_000_000, 10_000_000);
                        default: base = sdcdc_pkg::BASE_CLOCK_RESET;
                    endcase
                    if (base == '0) begin
                        base = 32'd1;
                    end
                    case ($urandom_range(3))
                        0: version = 8'd0;
                        1: version = 8'd1;
                        2: version = 8'($urandom_range(255, 2));
                        default: version = 8'($urandom());
                    endcase
                end
            endcase
            configure(base, version);
            case (phase % 4)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 78;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 78;
                end
                default: begin
                    sender_idle_pct = 24;
                    receiver_stall_pct = 24;
                end
            endcase
            for (item = 0; item < ITEMS_PER_PHASE; item++) begin
                if (phase == 4 && item == 10) begin
                    holdoff_left = HOLDOFF_CYCLES;
                end
                case ($urandom_range(9))
                    0: target = '0;
                    1, 2: target = $urandom();
                    3: target = cur_base_clock + $urandom_range(1000, 1);
                    default: begin
                        ratio = ($urandom_range(3) == 0) ? $urandom_range(16, 1)
                                                         : $urandom_range(2048, 1);
                        target = cur_base_clock / ratio;
                        if (target == '0) begin
                            target = $urandom_range(3, 1);
                        end
                        target = target + $urandom_range(2) - 1;
                    end
                endcase
                send_request(target, 1'b0, '0);
            end
        end

        drain_requests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
